// ----- rtl/jetp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Julia escape-time pixel: shared package
// Number format, escape limits, register map, sequencer states and the
// control/status bundles passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package jetp_pkg;

   localparam int unsigned ITER_LIMIT_DEFAULT = 100;

   // Q19.20 two's complement
   localparam int unsigned FIX_W  = 40;
   localparam int unsigned FRAC_W = 20;

   // |z| components below the escape bound fit in 28 bits (200 < 2^8)
   localparam int unsigned MAG_W  = 28;
   localparam int unsigned PROD_W = 2 * MAG_W;
   // signed width of zx^2 - zy^2 and 2*zx*zy
   localparam int unsigned DIFF_W = PROD_W + 2;

   localparam logic [FIX_W-1:0]  ESC_LIM    = FIX_W'(64'd200 << FRAC_W);
   localparam logic [PROD_W:0]   ESC_LIM_SQ = (PROD_W + 1)'(64'd40000 << (2 * FRAC_W));

   localparam int unsigned COLOUR_W  = 9;
   localparam int unsigned COLUMN_W  = 10;
   localparam logic [COLOUR_W-1:0] COLOUR_STEP = COLOUR_W'(5);

   localparam int unsigned CSR_ADDR_W = 6;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_IDX_LO = 3;

   typedef enum logic [2:0] {
      REG_X_MIN,
      REG_Y_MAX,
      REG_STEP_X,
      REG_STEP_Y,
      REG_C_RE,
      REG_C_IM
   } reg_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD
   } state_type;

   typedef struct packed {
      logic signed [FIX_W-1:0] x_min;
      logic signed [FIX_W-1:0] y_max;
      logic signed [FIX_W-1:0] step_x;
      logic signed [FIX_W-1:0] step_y;
      logic signed [FIX_W-1:0] c_re;
      logic signed [FIX_W-1:0] c_im;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic mul_en;
      logic upd_en;
   } dp_ctrl_type;

   typedef struct packed {
      logic escape;
   } dp_stat_type;

endpackage
`default_nettype wire

// ----- rtl/julia_escape_time_pixel_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Julia escape-time pixel unit
// Maps a pixel to a start point and iterates z = z*z + c until |z| > 200
// or the iteration limit, returning the escape colour.
// ----------------------------------------------------------------------------
// A pixel is taken when start is high and busy is low; busy then stays high
// until the result. Each iteration is a multiply step, then an update step,
// through one shared bank of product registers; the result comes on
// rsp_strobe once the pixel escapes or reaches ITER_LIMIT iterations.
// busy falls in the cycle the result shows, so the next pixel may start then.
// rsp_strobe is high for exactly one cycle and cannot be stalled: the
// receiver must capture colour and escaped in that cycle. Program the
// registers only while busy is low.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_unit #(
   parameter int unsigned ITER_LIMIT = jetp_pkg::ITER_LIMIT_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire logic [jetp_pkg::COLUMN_W-1:0]       req_col,
   input  wire logic [jetp_pkg::COLUMN_W-1:0]       req_row,
   output      logic                                rsp_strobe,
   output      logic [jetp_pkg::COLOUR_W-1:0]       rsp_colour,
   output      logic                                rsp_escaped,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [jetp_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [jetp_pkg::CSR_DATA_W-1:0]     pwdata,
   output      logic [jetp_pkg::CSR_DATA_W-1:0]     prdata,
   output      logic                                pready
);

   jetp_pkg::cfg_type     cfg;
   jetp_pkg::dp_ctrl_type ctrl;
   jetp_pkg::dp_stat_type stat;

   jetp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   jetp_iter_unit u_iter (
      .clock (clock),
      .ctrl  (ctrl),
      .cfg   (cfg),
      .col   (req_col),
      .row   (req_row),
      .stat  (stat)
   );

   jetp_ctrl #(
      .ITER_LIMIT (ITER_LIMIT)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .stat        (stat),
      .ctrl        (ctrl),
      .rsp_strobe  (rsp_strobe),
      .rsp_colour  (rsp_colour),
      .rsp_escaped (rsp_escaped)
   );

endmodule
`default_nettype wire

// ----- rtl/jetp_csr.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Julia escape-time pixel: configuration registers
// APB-style register file holding the image window and the Julia constant.
// ----------------------------------------------------------------------------
module jetp_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [jetp_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [jetp_pkg::CSR_DATA_W-1:0]     pwdata,
   output      logic [jetp_pkg::CSR_DATA_W-1:0]     prdata,
   output      logic                                pready,
   output      jetp_pkg::cfg_type                   cfg
);

   localparam int unsigned PadW = jetp_pkg::CSR_DATA_W - jetp_pkg::FIX_W;

   jetp_pkg::cfg_type     cfg_ff, cfg_in;
   jetp_pkg::reg_idx_type idx;
   logic                  wr_en;
   logic [jetp_pkg::FIX_W-1:0] wdata;
   logic [jetp_pkg::FIX_W-1:0] rdata;

   assign idx    = jetp_pkg::reg_idx_type'(paddr[jetp_pkg::CSR_ADDR_W-1:jetp_pkg::CSR_IDX_LO]);
   assign wr_en  = psel && penable && pwrite;
   assign wdata  = pwdata[jetp_pkg::FIX_W-1:0];
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            jetp_pkg::REG_X_MIN:  cfg_in.x_min  = wdata;
            jetp_pkg::REG_Y_MAX:  cfg_in.y_max  = wdata;
            jetp_pkg::REG_STEP_X: cfg_in.step_x = wdata;
            jetp_pkg::REG_STEP_Y: cfg_in.step_y = wdata;
            jetp_pkg::REG_C_RE:   cfg_in.c_re   = wdata;
            jetp_pkg::REG_C_IM:   cfg_in.c_im   = wdata;
            default: ;  // drop writes beyond the map
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         jetp_pkg::REG_X_MIN:  rdata = cfg_ff.x_min;
         jetp_pkg::REG_Y_MAX:  rdata = cfg_ff.y_max;
         jetp_pkg::REG_STEP_X: rdata = cfg_ff.step_x;
         jetp_pkg::REG_STEP_Y: rdata = cfg_ff.step_y;
         jetp_pkg::REG_C_RE:   rdata = cfg_ff.c_re;
         jetp_pkg::REG_C_IM:   rdata = cfg_ff.c_im;
         default:              rdata = '0;
      endcase
   end

   assign prdata = {{PadW{1'b0}}, rdata};
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/jetp_iter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Julia escape-time pixel: complex iteration unit
// Holds z, squares it through one bank of product registers and applies
// z <= z*z + c; flags escape on |z|^2 > 40000 before each update.
// ----------------------------------------------------------------------------
module jetp_iter_unit (
   input  wire logic                                clock,
   input  wire jetp_pkg::dp_ctrl_type               ctrl,
   input  wire jetp_pkg::cfg_type                   cfg,
   input  wire logic [jetp_pkg::COLUMN_W-1:0]       col,
   input  wire logic [jetp_pkg::COLUMN_W-1:0]       row,
   output      jetp_pkg::dp_stat_type               stat
);

   localparam int unsigned FixW  = jetp_pkg::FIX_W;
   localparam int unsigned MagW  = jetp_pkg::MAG_W;
   localparam int unsigned ProdW = jetp_pkg::PROD_W;
   localparam int unsigned DiffW = jetp_pkg::DIFF_W;
   localparam int unsigned FracW = jetp_pkg::FRAC_W;
   localparam int unsigned ExtW  = FixW - (DiffW - FracW);

   logic [FixW-1:0]  zx_ff, zx_in, zy_ff, zy_in;
   logic [ProdW-1:0] pxx_ff, pxx_in, pyy_ff, pyy_in, pxy_ff, pxy_in;
   logic             neg_ff, neg_in, big_ff, big_in;

   logic [FixW-1:0]  ax, ay;
   logic [FixW-1:0]  col_term, row_term;
   logic [ProdW:0]   mag_sq;
   logic [DiffW-1:0] sq, cr_mag, cr;
   logic [FixW-1:0]  nx, ny;

   // start point, wrapping modulo 2^40
   assign col_term = FixW'(FixW'(col) * cfg.step_x);
   assign row_term = FixW'(FixW'(row) * cfg.step_y);

   // multiply step: magnitudes through the product bank
   assign ax = zx_ff[FixW-1] ? (~zx_ff + 1'b1) : zx_ff;
   assign ay = zy_ff[FixW-1] ? (~zy_ff + 1'b1) : zy_ff;

   always_comb begin
      pxx_in = pxx_ff;
      pyy_in = pyy_ff;
      pxy_in = pxy_ff;
      neg_in = neg_ff;
      big_in = big_ff;
      if (ctrl.mul_en) begin
         pxx_in = ax[MagW-1:0] * ax[MagW-1:0];
         pyy_in = ay[MagW-1:0] * ay[MagW-1:0];
         pxy_in = ax[MagW-1:0] * ay[MagW-1:0];
         neg_in = zx_ff[FixW-1] ^ zy_ff[FixW-1];
         // one component alone beyond the bound: products are not valid
         big_in = (ax > jetp_pkg::ESC_LIM) || (ay > jetp_pkg::ESC_LIM);
      end
   end

   // update step: escape test and z*z + c with floor shift
   assign mag_sq      = {1'b0, pxx_ff} + {1'b0, pyy_ff};
   assign stat.escape = big_ff || (mag_sq > jetp_pkg::ESC_LIM_SQ);

   assign sq     = {2'b00, pxx_ff} - {2'b00, pyy_ff};
   assign cr_mag = {1'b0, pxy_ff, 1'b0};
   assign cr     = neg_ff ? (~cr_mag + 1'b1) : cr_mag;

   assign nx = {{ExtW{sq[DiffW-1]}}, sq[DiffW-1:FracW]} + cfg.c_re;
   assign ny = {{ExtW{cr[DiffW-1]}}, cr[DiffW-1:FracW]} + cfg.c_im;

   always_comb begin
      zx_in = zx_ff;
      zy_in = zy_ff;
      if (ctrl.load) begin
         zx_in = cfg.x_min + col_term;
         zy_in = cfg.y_max - row_term;
      end else if (ctrl.upd_en) begin
         zx_in = nx;
         zy_in = ny;
      end
   end

   always_ff @(posedge clock) begin
      zx_ff  <= zx_in;
      zy_ff  <= zy_in;
      pxx_ff <= pxx_in;
      pyy_ff <= pyy_in;
      pxy_ff <= pxy_in;
      neg_ff <= neg_in;
      big_ff <= big_in;
   end

endmodule
`default_nettype wire

// ----- rtl/jetp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Julia escape-time pixel: sequencer
// Alternates the multiply and update steps of the iteration unit, counts
// iterations and the running colour, and registers the result.
// ----------------------------------------------------------------------------
module jetp_ctrl #(
   parameter int unsigned ITER_LIMIT = jetp_pkg::ITER_LIMIT_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire jetp_pkg::dp_stat_type               stat,
   output      jetp_pkg::dp_ctrl_type               ctrl,
   output      logic                                rsp_strobe,
   output      logic [jetp_pkg::COLOUR_W-1:0]       rsp_colour,
   output      logic                                rsp_escaped
);

   localparam int unsigned IterW = $clog2(ITER_LIMIT + 1);

   jetp_pkg::state_type state_ff, state_in;

   logic [IterW-1:0]              iter_ff, iter_in;
   logic [jetp_pkg::COLOUR_W-1:0] colour_ff, colour_in;
   logic                          strobe_ff, strobe_in;
   logic [jetp_pkg::COLOUR_W-1:0] res_colour_ff, res_colour_in;
   logic                          res_esc_ff, res_esc_in;
   logic                          last;
   logic                          finish;

   assign last   = (iter_ff == IterW'(ITER_LIMIT - 1));
   assign finish = ctrl.upd_en && (stat.escape || last);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jetp_pkg::ST_IDLE: if (start) state_in = jetp_pkg::ST_MUL;
         jetp_pkg::ST_MUL:  state_in = jetp_pkg::ST_UPD;
         jetp_pkg::ST_UPD: begin
            if (stat.escape || last) state_in = jetp_pkg::ST_IDLE;
            else                     state_in = jetp_pkg::ST_MUL;
         end
         default:           state_in = jetp_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl = '0;
      busy = 1'b1;
      unique case (state_ff)
         jetp_pkg::ST_IDLE: begin
            busy      = 1'b0;
            ctrl.load = start;
         end
         jetp_pkg::ST_MUL:  ctrl.mul_en = 1'b1;
         jetp_pkg::ST_UPD:  ctrl.upd_en = 1'b1;
         default:           busy = 1'b0;
      endcase
   end

   // iteration count and colour, advanced on every update that stays inside
   always_comb begin
      iter_in   = iter_ff;
      colour_in = colour_ff;
      if (ctrl.load) begin
         iter_in   = '0;
         colour_in = '0;
      end else if (ctrl.upd_en && !stat.escape) begin
         iter_in   = iter_ff + 1'b1;
         colour_in = colour_ff + jetp_pkg::COLOUR_STEP;
      end
   end

   always_comb begin
      strobe_in     = finish;
      res_colour_in = res_colour_ff;
      res_esc_in    = res_esc_ff;
      if (finish) begin
         res_esc_in    = stat.escape;
         res_colour_in = stat.escape ? colour_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= jetp_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff       <= iter_in;
      colour_ff     <= colour_in;
      res_colour_ff <= res_colour_in;
      res_esc_ff    <= res_esc_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_colour  = res_colour_ff;
   assign rsp_escaped = res_esc_ff;

endmodule
`default_nettype wire

// ----- rtl/jetp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Julia escape-time pixel: port checker
// Watches the command and result ports of the pixel unit over time.
// ----------------------------------------------------------------------------
module jetp_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic                                busy,
   input  wire logic                                rsp_strobe,
   input  wire logic [jetp_pkg::COLOUR_W-1:0]       rsp_colour,
   input  wire logic                                rsp_escaped
);

   // a taken pixel keeps the unit busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after a transaction was taken");

   // busy only drops together with a result
   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result");

   // no result while still working
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // results never come back to back
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // a pixel that never escaped has colour zero
   a_no_escape_black: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_escaped |-> rsp_colour == '0)
      else $error("non-zero colour without escape");

endmodule

bind julia_escape_time_pixel_unit jetp_checker u_jetp_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_colour  (rsp_colour),
   .rsp_escaped (rsp_escaped)
);
`default_nettype wire

// ----- verif/escape_colour_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Julia escape-time pixel unit: result checker
// Watches the register port and the pixel and colour channels, keeps its own
// copy of the view registers, works out the escape colour of every accepted
// pixel and compares each returned colour with the oldest one still owed.
// ----------------------------------------------------------------------------
module escape_colour_check #(
   parameter int unsigned ITER_LIMIT = jetp_pkg::ITER_LIMIT_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            busy,
   input  wire logic [jetp_pkg::COLUMN_W-1:0]   req_col,
   input  wire logic [jetp_pkg::COLUMN_W-1:0]   req_row,
   input  wire logic                            rsp_strobe,
   input  wire logic [jetp_pkg::COLOUR_W-1:0]   rsp_colour,
   input  wire logic                            rsp_escaped,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [jetp_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [jetp_pkg::CSR_DATA_W-1:0] pwdata,
   input  wire logic                            pready,
   output int                                   colours_owed,
   output int                                   colour_faults
);
   import jetp_pkg::*;

   typedef struct {
      logic [COLUMN_W-1:0] col;
      logic [COLUMN_W-1:0] row;
      logic [COLOUR_W-1:0] colour;
      logic                escaped;
   } pixel_colour_t;

   localparam logic [63:0] RADIUS_FIX    = 64'd200 << FRAC_W;
   localparam logic [63:0] RADIUS_SQ_FIX = 64'd40000 << (2 * FRAC_W);
   localparam int unsigned COLOUR_PER_ITER = 5;

   cfg_type       view;
   pixel_colour_t owed_q[$];
   int            reported;

   // Iterate z = z*z + c from the pixel's start point until |z| > 200 or ITER_LIMIT iterations.
   function automatic pixel_colour_t escape_colour(input logic [COLUMN_W-1:0] col,
                                                   input logic [COLUMN_W-1:0] row,
                                                   input cfg_type v);
      logic signed [FIX_W-1:0] zx;
      logic signed [FIX_W-1:0] zy;
      logic [FIX_W-1:0]        ax;
      logic [FIX_W-1:0]        ay;
      logic [63:0]             mag_sq;
      longint                  sq;
      longint                  cr;
      int                      i;
      pixel_colour_t           res;
      res.col     = col;
      res.row     = row;
      res.colour  = '0;
      res.escaped = 1'b0;
      zx = FIX_W'(v.x_min + FIX_W'(col) * v.step_x);
      zy = FIX_W'(v.y_max - FIX_W'(row) * v.step_y);
      i  = 0;
      while (i < int'(ITER_LIMIT) && !res.escaped) begin
         ax = zx[FIX_W-1] ? FIX_W'(-zx) : zx;
         ay = zy[FIX_W-1] ? FIX_W'(-zy) : zy;
         if (64'(ax) > RADIUS_FIX || 64'(ay) > RADIUS_FIX) begin
            res.escaped = 1'b1;
         end else begin
            mag_sq = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
            res.escaped = (mag_sq > RADIUS_SQ_FIX);
         end
         if (res.escaped) begin
            res.colour = COLOUR_W'(i * COLOUR_PER_ITER);
         end else begin
            sq = longint'(zx) * longint'(zx) - longint'(zy) * longint'(zy);
            cr = 2 * longint'(zx) * longint'(zy);
            // arithmetic shift floors toward minus infinity
            zx = FIX_W'((sq >>> FRAC_W) + longint'(v.c_re));
            zy = FIX_W'((cr >>> FRAC_W) + longint'(v.c_im));
            i++;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      pixel_colour_t exp_c;
      int            faults;
      faults = 0;
      if (reset) begin
         view = '0;
         owed_q.delete();
         reported = 0;
         colours_owed  <= 0;
         colour_faults <= 0;
      end else begin
         if (rsp_strobe) begin
            if (owed_q.size() == 0) begin
               faults++;
               if (reported < 10) begin
                  $display("%0t: colour %0d escaped %0d returned with no pixel pending",
                           $realtime, rsp_colour, rsp_escaped);
               end
               reported++;
            end else begin
               exp_c = owed_q.pop_front();
               if (rsp_colour !== exp_c.colour || rsp_escaped !== exp_c.escaped) begin
                  faults++;
                  if (reported < 10) begin
                     $display("%0t: pixel (%0d,%0d) colour exp %0d got %0d, escaped exp %0d got %0d",
                              $realtime, exp_c.col, exp_c.row, exp_c.colour, rsp_colour,
                              exp_c.escaped, rsp_escaped);
                  end
                  reported++;
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:CSR_IDX_LO])
               REG_X_MIN:  view.x_min  = pwdata[FIX_W-1:0];
               REG_Y_MAX:  view.y_max  = pwdata[FIX_W-1:0];
               REG_STEP_X: view.step_x = pwdata[FIX_W-1:0];
               REG_STEP_Y: view.step_y = pwdata[FIX_W-1:0];
               REG_C_RE:   view.c_re   = pwdata[FIX_W-1:0];
               REG_C_IM:   view.c_im   = pwdata[FIX_W-1:0];
               default: ; // drop writes to unmapped indexes
            endcase
         end
         if (start && !busy) begin
            owed_q.push_back(escape_colour(req_col, req_row, view));
         end
         colours_owed  <= owed_q.size();
         colour_faults <= colour_faults + faults;
      end
   end

endmodule

// ----- verif/julia_escape_time_pixel_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Julia escape-time pixel unit: testbench top
// Programs a series of views and Julia constants over the register port,
// feeds pixels with random gaps and leaves the checking to the colour
// checker beside the block; prints the verdict once every colour is back.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_unit_test;
   import jetp_pkg::*;

   localparam int unsigned PIXEL_ITER_LIMIT = ITER_LIMIT_DEFAULT;
   localparam int unsigned REG_SPARE_A      = 6;
   localparam int unsigned REG_SPARE_B      = 7;
   localparam int unsigned RANDOM_PHASES    = 16;
   localparam int unsigned PHASE_PIXELS     = 58;
   localparam longint      FIX_ONE          = longint'(1) << FRAC_W;
   localparam longint      FIX_MAX          = (longint'(1) << (FIX_W - 1)) - 1;
   localparam longint      FIX_MIN          = -(longint'(1) << (FIX_W - 1));
   localparam logic [COLUMN_W-1:0] EDGE_MAX = '1;

   logic                  clock;
   logic                  reset   = 1'b1;
   logic                  start   = 1'b0;
   logic [COLUMN_W-1:0]   req_col = '0;
   logic [COLUMN_W-1:0]   req_row = '0;
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic                  busy;
   logic                  rsp_strobe;
   logic [COLOUR_W-1:0]   rsp_colour;
   logic                  rsp_escaped;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    colours_owed;
   int                    colour_faults;

   julia_escape_time_pixel_unit #(
      .ITER_LIMIT(PIXEL_ITER_LIMIT)
   ) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_col(req_col), .req_row(req_row),
      .rsp_strobe(rsp_strobe), .rsp_colour(rsp_colour), .rsp_escaped(rsp_escaped),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   escape_colour_check #(
      .ITER_LIMIT(PIXEL_ITER_LIMIT)
   ) u_colour_check (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_col(req_col), .req_row(req_row),
      .rsp_strobe(rsp_strobe), .rsp_colour(rsp_colour), .rsp_escaped(rsp_escaped),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .colours_owed(colours_owed), .colour_faults(colour_faults)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [FIX_W-1:0] to_fix(input longint v);
      return FIX_W'(v);
   endfunction

   function automatic logic [FIX_W-1:0] rand_fix(input longint span);
      return to_fix(longint'($urandom_range(32'(2 * span))) - span);
   endfunction

   function automatic logic [COLUMN_W-1:0] rand_edge();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick == 0) return '0;
      if (pick == 1) return EDGE_MAX;
      return COLUMN_W'($urandom);
   endfunction

   // Setup cycle, then access cycle; junk in the upper data bits must be dropped.
   task automatic csr_write(input int unsigned idx, input logic [FIX_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx << CSR_IDX_LO);
      pwdata  <= {(CSR_DATA_W - FIX_W)'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic program_view(input logic [FIX_W-1:0] x_min, y_max, step_x, step_y,
                               input logic [FIX_W-1:0] c_re, c_im);
      csr_write(REG_X_MIN, x_min);
      csr_write(REG_Y_MAX, y_max);
      csr_write(REG_STEP_X, step_x);
      csr_write(REG_STEP_Y, step_y);
      csr_write(REG_C_RE, c_re);
      csr_write(REG_C_IM, c_im);
   endtask

   // Hold the pixel until the transaction is taken.
   task automatic send_pixel(input logic [COLUMN_W-1:0] col, row, input int unsigned idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start   <= 1'b0;
         req_col <= COLUMN_W'($urandom);
         req_row <= COLUMN_W'($urandom);
         @(posedge clock);
      end
      start   <= 1'b1;
      req_col <= col;
      req_row <= row;
      do @(posedge clock); while (busy);
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (busy || colours_owed != 0);
   endtask

   initial begin : stimulus
      int unsigned idle_pct;
      int unsigned kind;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset view: every pixel maps to zero and never escapes
      send_pixel('0, '0, 0);
      send_pixel(EDGE_MAX, EDGE_MAX, 0);
      settle();

      // |z| exactly on the bound does not escape; one step past it does
      csr_write(REG_X_MIN, to_fix(200 * FIX_ONE));
      send_pixel('0, '0, 0);
      settle();
      csr_write(REG_X_MIN, to_fix(200 * FIX_ONE + 1));
      send_pixel(10'd5, 10'd7, 0);
      settle();
      csr_write(REG_X_MIN, '0);
      csr_write(REG_Y_MAX, to_fix(-200 * FIX_ONE));
      send_pixel(EDGE_MAX, '0, 0);
      settle();

      // escape decided by c alone: one large part, then only the squared sum
      program_view('0, '0, '0, '0, to_fix(300 * FIX_ONE), '0);
      send_pixel('0, '0, 0);
      settle();
      csr_write(REG_C_RE, to_fix(150 * FIX_ONE));
      csr_write(REG_C_IM, to_fix(150 * FIX_ONE));
      send_pixel('0, EDGE_MAX, 0);
      settle();
      csr_write(REG_C_RE, to_fix(141 * FIX_ONE));
      csr_write(REG_C_IM, to_fix(141 * FIX_ONE));
      send_pixel(10'd1, 10'd1, 0);
      settle();

      // register extremes: start points wrap modulo 2^40
      program_view(to_fix(FIX_MAX), to_fix(FIX_MIN), to_fix(FIX_MIN), to_fix(FIX_MAX),
                   to_fix(FIX_MAX), to_fix(FIX_MIN));
      send_pixel('0, '0, 0);
      send_pixel(10'd1, 10'd1, 0);
      send_pixel(EDGE_MAX, '0, 0);
      send_pixel('0, EDGE_MAX, 0);
      send_pixel(EDGE_MAX, EDGE_MAX, 0);
      send_pixel(10'd512, 10'd511, 0);
      settle();

      // classic view; writes to unmapped indexes must leave it alone
      program_view(to_fix(-3 * FIX_ONE / 2), to_fix(3 * FIX_ONE / 2), to_fix(3072),
                   to_fix(3072), to_fix(-838861), to_fix(163578));
      csr_write(REG_SPARE_A, to_fix({$urandom, $urandom}));
      csr_write(REG_SPARE_B, to_fix({$urandom, $urandom}));
      send_pixel(10'd512, 10'd512, 0);
      send_pixel(10'd300, 10'd600, 0);
      send_pixel('0, EDGE_MAX, 0);
      send_pixel(10'd700, 10'd400, 0);
      send_pixel(10'd256, 10'd512, 0);
      settle();

      for (int phase = 0; phase < int'(RANDOM_PHASES); phase++) begin
         case (phase % 3)
            0:       idle_pct = 0;
            1:       idle_pct = 52;
            default: idle_pct = 11;
         endcase
         kind = $urandom_range(9);
         if (kind < 7) begin
            // view around the set: long orbits
            program_view(to_fix(-(FIX_ONE + longint'($urandom_range(32'(FIX_ONE))))),
                         to_fix(FIX_ONE + longint'($urandom_range(32'(FIX_ONE)))),
                         to_fix(1024 + $urandom_range(3072)),
                         to_fix(1024 + $urandom_range(3072)),
                         rand_fix(FIX_ONE), rand_fix(FIX_ONE));
         end else if (kind < 9) begin
            program_view(rand_fix(longint'(1) << 28), rand_fix(longint'(1) << 28),
                         rand_fix(FIX_ONE), rand_fix(FIX_ONE),
                         rand_fix(longint'(1) << 28), rand_fix(longint'(1) << 28));
         end else begin
            program_view(to_fix({$urandom, $urandom}), to_fix({$urandom, $urandom}),
                         to_fix({$urandom, $urandom}), to_fix({$urandom, $urandom}),
                         to_fix({$urandom, $urandom}), to_fix({$urandom, $urandom}));
         end
         repeat (PHASE_PIXELS) send_pixel(rand_edge(), rand_edge(), idle_pct);
         settle();
      end

      repeat (2 * PIXEL_ITER_LIMIT + 10) @(posedge clock);
      if (colour_faults == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
